[rtl/core/plt_pkg.sv]
`default_nettype none

package plt_pkg;

   localparam int DEPTH     = 64;
   localparam int IDX_W     = 6;
   localparam int KEY_W     = 32;
   localparam int PAY_W     = 64;
   localparam int STAT_W    = 3;
   localparam int CNT_OUT_W = 7;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int POS_W     = $clog2(DEPTH);
   // wide enough for any position, count or index compare
   localparam int WIDE_W    = CNT_W + IDX_W;

   typedef logic [WIDE_W-1:0] wide_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [POS_W-1:0]  pos_type;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BADINDEX = 3'd4;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             ins_en;
      logic             del_en;
      logic             srch_en;
      logic             rd_en;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      cnt_type          count;
   } plt_ctl_type;

   // lookup wave that walks the row one cell per cycle
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IDX_W-1:0] pos;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } plt_pkt_type;

endpackage

`default_nettype wire

[rtl/core/positional_list_table_core.sv]
// insert/delete: rsp_strobe is registered from ST_EXEC, and busy drops as it rises
// search/read: a lookup wave walks the row of DEPTH cells, one cell per cycle,
//   so rsp_strobe comes once the wave leaves the tail cell, and busy drops as it rises
// one result per item, shown for one cycle; the receiver cannot stall
// synchronous reset empties the list and cancels any item in flight
`default_nettype none

module positional_list_table_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire [1:0]                            req_opcode,
   input  wire [plt_pkg::IDX_W-1:0]             req_index,
   input  wire signed [plt_pkg::KEY_W-1:0]      req_key,
   input  wire [plt_pkg::PAY_W-1:0]             req_payload,
   output logic                                 rsp_strobe,
   output logic [plt_pkg::STAT_W-1:0]           rsp_status,
   output logic [plt_pkg::IDX_W-1:0]            rsp_found_index,
   output logic signed [plt_pkg::KEY_W-1:0]     rsp_entry_key,
   output logic [plt_pkg::PAY_W-1:0]            rsp_entry_payload,
   output logic [plt_pkg::CNT_OUT_W-1:0]        rsp_count
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [1:0]                      op_ff;
   logic [plt_pkg::IDX_W-1:0]       idx_ff;
   logic [plt_pkg::KEY_W-1:0]       key_ff;
   logic [plt_pkg::PAY_W-1:0]       pay_ff;
   plt_pkg::cnt_type                count_ff, count_in;

   logic                            strobe_ff, strobe_in;
   logic [plt_pkg::STAT_W-1:0]      status_ff, status_in;
   logic [plt_pkg::IDX_W-1:0]       fidx_ff, fidx_in;
   logic [plt_pkg::KEY_W-1:0]       okey_ff, okey_in;
   logic [plt_pkg::PAY_W-1:0]       opay_ff, opay_in;
   logic [plt_pkg::CNT_OUT_W-1:0]   ocnt_ff;

   plt_pkg::plt_ctl_type            ctl;
   plt_pkg::plt_pkt_type            pkt_chain [plt_pkg::DEPTH+1];
   logic [plt_pkg::KEY_W-1:0]       cell_key [plt_pkg::DEPTH];
   logic [plt_pkg::PAY_W-1:0]       cell_pay [plt_pkg::DEPTH];
   logic [plt_pkg::KEY_W-1:0]       prev_key [plt_pkg::DEPTH];
   logic [plt_pkg::PAY_W-1:0]       prev_pay [plt_pkg::DEPTH];
   logic [plt_pkg::KEY_W-1:0]       next_key [plt_pkg::DEPTH];
   logic [plt_pkg::PAY_W-1:0]       next_pay [plt_pkg::DEPTH];
   logic [plt_pkg::DEPTH-1:0]       chain_valid;

   logic                            accept;
   logic                            inject;
   logic                            ins_en, del_en;
   plt_pkg::wide_type               idx_wide, cnt_wide, cnt_out_wide;
   plt_pkg::plt_pkt_type            tail;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign idx_wide = plt_pkg::wide_type'(idx_ff);
   assign cnt_wide = plt_pkg::wide_type'(count_ff);
   assign tail     = pkt_chain[plt_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         idx_ff <= req_index;
         key_ff <= req_key;
         pay_ff <= req_payload;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ins_en    = 1'b0;
      del_en    = 1'b0;
      inject    = 1'b0;
      strobe_in = 1'b0;
      status_in = plt_pkg::STAT_OK;
      fidx_in   = idx_ff;
      okey_in   = '0;
      opay_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               plt_pkg::OP_INSERT: begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
                  if (count_ff >= plt_pkg::cnt_type'(plt_pkg::DEPTH)) begin
                     status_in = plt_pkg::STAT_FULL;
                  end else if (idx_wide > cnt_wide) begin
                     status_in = plt_pkg::STAT_BADINDEX;
                  end else begin
                     ins_en   = 1'b1;
                     count_in = count_ff + plt_pkg::cnt_type'(1);
                  end
               end
               plt_pkg::OP_DELETE: begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
                  if (count_ff == '0) begin
                     status_in = plt_pkg::STAT_EMPTY;
                  end else if (idx_wide >= cnt_wide) begin
                     status_in = plt_pkg::STAT_BADINDEX;
                  end else begin
                     del_en   = 1'b1;
                     count_in = count_ff - plt_pkg::cnt_type'(1);
                  end
               end
               default: begin
                  inject   = 1'b1;
                  state_in = ST_SCAN;
               end
            endcase
         end
         ST_SCAN: begin
            if (tail.valid) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
               case (op_ff)
                  plt_pkg::OP_SEARCH: begin
                     if (tail.hit) begin
                        fidx_in = tail.pos;
                        okey_in = tail.key;
                        opay_in = tail.payload;
                     end else begin
                        status_in = plt_pkg::STAT_NOTFOUND;
                        fidx_in   = '0;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = plt_pkg::STAT_EMPTY;
                     end else if (idx_wide >= cnt_wide) begin
                        status_in = plt_pkg::STAT_BADINDEX;
                     end else begin
                        okey_in = tail.key;
                        opay_in = tail.payload;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign cnt_out_wide = plt_pkg::wide_type'(count_in);

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      fidx_ff   <= fidx_in;
      okey_ff   <= okey_in;
      opay_ff   <= opay_in;
      ocnt_ff   <= cnt_out_wide[plt_pkg::CNT_OUT_W-1:0];
   end

   assign ctl.ins_en  = ins_en;
   assign ctl.del_en  = del_en;
   assign ctl.srch_en = (op_ff == plt_pkg::OP_SEARCH);
   assign ctl.rd_en   = (op_ff == plt_pkg::OP_READ);
   assign ctl.idx     = idx_ff;
   assign ctl.key     = key_ff;
   assign ctl.payload = pay_ff;
   assign ctl.count   = count_ff;

   // a fresh lookup wave enters the head of the row
   assign pkt_chain[0] = '{valid: inject, default: '0};

   for (genvar i = 0; i < plt_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_key[i] = key_ff;
         assign prev_pay[i] = pay_ff;
      end else begin : g_mid
         assign prev_key[i] = cell_key[i-1];
         assign prev_pay[i] = cell_pay[i-1];
      end
      if (i == plt_pkg::DEPTH - 1) begin : g_tail
         assign next_key[i] = cell_key[i];
         assign next_pay[i] = cell_pay[i];
      end else begin : g_body
         assign next_key[i] = cell_key[i+1];
         assign next_pay[i] = cell_pay[i+1];
      end

      plt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_pos     (plt_pkg::pos_type'(i)),
         .ctl          (ctl),
         .prev_key     (prev_key[i]),
         .prev_payload (prev_pay[i]),
         .next_key     (next_key[i]),
         .next_payload (next_pay[i]),
         .cell_key     (cell_key[i]),
         .cell_payload (cell_pay[i]),
         .pkt_in       (pkt_chain[i]),
         .pkt_out      (pkt_chain[i+1])
      );

      assign chain_valid[i] = pkt_chain[i+1].valid;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_found_index   = fidx_ff;
   assign rsp_entry_key     = okey_ff;
   assign rsp_entry_payload = opay_ff;
   assign rsp_count         = ocnt_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result shown while an item is still in work");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= plt_pkg::cnt_type'(plt_pkg::DEPTH))
      else $error("entry count beyond depth");

   a_one_wave: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid) <= 1)
      else $error("more than one lookup wave in the row");

   a_count_moves_with_result: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> strobe_ff)
      else $error("entry count changed without a result");

   a_wave_only_when_scanning: assert property (@(posedge clock) disable iff (reset)
      (chain_valid != '0) |-> (state_ff == ST_SCAN))
      else $error("lookup wave outside a scan");

endmodule

`default_nettype wire

[rtl/core/plt_cell.sv]
`default_nettype none

module plt_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  wire plt_pkg::pos_type         cell_pos,
   input  wire plt_pkg::plt_ctl_type     ctl,
   input  wire [plt_pkg::KEY_W-1:0]      prev_key,
   input  wire [plt_pkg::PAY_W-1:0]      prev_payload,
   input  wire [plt_pkg::KEY_W-1:0]      next_key,
   input  wire [plt_pkg::PAY_W-1:0]      next_payload,
   output logic [plt_pkg::KEY_W-1:0]     cell_key,
   output logic [plt_pkg::PAY_W-1:0]     cell_payload,
   input  wire plt_pkg::plt_pkt_type     pkt_in,
   output plt_pkg::plt_pkt_type          pkt_out
);

   logic [plt_pkg::KEY_W-1:0] key_ff;
   logic [plt_pkg::KEY_W-1:0] key_in;
   logic [plt_pkg::PAY_W-1:0] pay_ff;
   logic [plt_pkg::PAY_W-1:0] pay_in;
   plt_pkg::plt_pkt_type      pkt_ff;
   plt_pkg::plt_pkt_type      pkt_in_next;
   plt_pkg::wide_type         pos_wide;
   plt_pkg::wide_type         idx_wide;
   plt_pkg::wide_type         cnt_wide;
   logic                      hit_here;

   assign pos_wide = plt_pkg::wide_type'(cell_pos);
   assign idx_wide = plt_pkg::wide_type'(ctl.idx);
   assign cnt_wide = plt_pkg::wide_type'(ctl.count);

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      if (ctl.ins_en && (pos_wide > idx_wide)) begin
         key_in = prev_key;
         pay_in = prev_payload;
      end else if (ctl.ins_en && (pos_wide == idx_wide)) begin
         key_in = ctl.key;
         pay_in = ctl.payload;
      end else if (ctl.del_en && (pos_wide >= idx_wide)) begin
         key_in = next_key;
         pay_in = next_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
   end

   assign hit_here = (ctl.srch_en && (key_ff == ctl.key) && (pos_wide < cnt_wide)) ||
                     (ctl.rd_en && (pos_wide == idx_wide));

   // first hit along the row wins, later cells pass it on
   always_comb begin
      pkt_in_next = pkt_in;
      if (!pkt_in.hit && hit_here) begin
         pkt_in_next.hit     = 1'b1;
         pkt_in_next.pos     = pos_wide[plt_pkg::IDX_W-1:0];
         pkt_in_next.key     = key_ff;
         pkt_in_next.payload = pay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff.valid <= 1'b0;
      end else begin
         pkt_ff.valid <= pkt_in_next.valid;
      end
      pkt_ff.hit     <= pkt_in_next.hit;
      pkt_ff.pos     <= pkt_in_next.pos;
      pkt_ff.key     <= pkt_in_next.key;
      pkt_ff.payload <= pkt_in_next.payload;
   end

   assign cell_key     = key_ff;
   assign cell_payload = pay_ff;
   assign pkt_out      = pkt_ff;

endmodule

`default_nettype wire

[test/positional_list_table_core_tb.sv]
`timescale 1ns / 100ps

module positional_list_table_core_tb;
   import plt_pkg::*;

   typedef struct {
      logic [1:0]              op;
      logic [IDX_W-1:0]        idx;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        pay;
      bit                      hold_until_idle;
   } list_cmd_type;

   typedef struct {
      logic [STAT_W-1:0]       status;
      logic [IDX_W-1:0]        pos;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        pay;
      logic [CNT_OUT_W-1:0]    count;
   } list_rsp_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [1:0]                  req_opcode = OP_INSERT;
   logic [IDX_W-1:0]            req_index = '0;
   logic signed [KEY_W-1:0]     req_key = '0;
   logic [PAY_W-1:0]            req_payload = '0;
   logic                        rsp_strobe;
   logic [STAT_W-1:0]           rsp_status;
   logic [IDX_W-1:0]            rsp_found_index;
   logic signed [KEY_W-1:0]     rsp_entry_key;
   logic [PAY_W-1:0]            rsp_entry_payload;
   logic [CNT_OUT_W-1:0]        rsp_count;

   positional_list_table_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_index         (req_index),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_found_index   (rsp_found_index),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_count         (rsp_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the table
   logic [KEY_W-1:0] tbl_keys [DEPTH];
   logic [PAY_W-1:0] tbl_pays [DEPTH];
   int               tbl_cnt = 0;

   list_cmd_type            cmd_backlog [$];
   list_rsp_type            rsp_due [$];
   logic signed [KEY_W-1:0] recent_keys [$];
   int                      gen_cnt = 0;
   int                      issued = 0;
   int                      err_cnt = 0;
   logic                    accept_seen = 1'b0;

   function automatic list_rsp_type apply_list_op(input logic [1:0] op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PAY_W-1:0] pay);
      list_rsp_type r;
      int           at;
      r.status = STAT_OK;
      r.pos    = idx;
      r.key    = '0;
      r.pay    = '0;
      at       = int'(idx);
      case (op)
         OP_INSERT: begin
            if (tbl_cnt >= DEPTH) begin
               r.status = STAT_FULL;
            end else if (at > tbl_cnt) begin
               r.status = STAT_BADINDEX;
            end else begin
               for (int i = tbl_cnt; i > at; i--) begin
                  tbl_keys[i] = tbl_keys[i-1];
                  tbl_pays[i] = tbl_pays[i-1];
               end
               tbl_keys[at] = key;
               tbl_pays[at] = pay;
               tbl_cnt++;
            end
         end
         OP_DELETE: begin
            if (tbl_cnt == 0) begin
               r.status = STAT_EMPTY;
            end else if (at >= tbl_cnt) begin
               r.status = STAT_BADINDEX;
            end else begin
               for (int i = at; i < tbl_cnt - 1; i++) begin
                  tbl_keys[i] = tbl_keys[i+1];
                  tbl_pays[i] = tbl_pays[i+1];
               end
               tbl_cnt--;
            end
         end
         OP_SEARCH: begin
            r.status = STAT_NOTFOUND;
            r.pos    = '0;
            for (int i = 0; i < tbl_cnt; i++) begin
               if (r.status == STAT_NOTFOUND && tbl_keys[i] == key) begin
                  r.status = STAT_OK;
                  r.pos    = IDX_W'(i);
                  r.key    = tbl_keys[i];
                  r.pay    = tbl_pays[i];
               end
            end
         end
         default: begin
            if (tbl_cnt == 0) begin
               r.status = STAT_EMPTY;
            end else if (at >= tbl_cnt) begin
               r.status = STAT_BADINDEX;
            end else begin
               r.key = tbl_keys[at];
               r.pay = tbl_pays[at];
            end
         end
      endcase
      r.count = CNT_OUT_W'(tbl_cnt);
      return r;
   endfunction

   // queue an item and track how the count will move
   task automatic push_cmd(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay, input bit hold);
      list_cmd_type c;
      c.op              = op;
      c.idx             = idx;
      c.key             = key;
      c.pay             = pay;
      c.hold_until_idle = hold;
      cmd_backlog.push_back(c);
      if (op == OP_INSERT && gen_cnt < DEPTH && int'(idx) <= gen_cnt) begin
         gen_cnt++;
         recent_keys.push_back(key);
         if (recent_keys.size() > 32) void'(recent_keys.pop_front());
      end else if (op == OP_DELETE && int'(idx) < gen_cnt) begin
         gen_cnt--;
      end
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return $signed(KEY_W'($urandom_range(15))) - 8;
      if (sel < 50) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic build_traffic();
      logic [1:0]              op;
      logic [IDX_W-1:0]        idx;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        pay;
      int                      r;
      bit                      growing;
      // empty list corners, then a small list with extreme keys and payloads
      push_cmd(OP_READ,   6'd0,  32'sd0, '0, 1'b0);
      push_cmd(OP_DELETE, 6'd63, 32'sd0, '0, 1'b0);
      push_cmd(OP_SEARCH, 6'd5,  32'sd0, '0, 1'b0);
      push_cmd(OP_INSERT, 6'd1,  32'sd7, 64'hffff_ffff_ffff_ffff, 1'b0);
      push_cmd(OP_INSERT, 6'd0,  32'sh8000_0000, 64'hffff_ffff_ffff_ffff, 1'b0);
      push_cmd(OP_INSERT, 6'd1,  32'sh7fff_ffff, 64'h0, 1'b0);
      push_cmd(OP_INSERT, 6'd0,  -32'sd1, 64'h5555_5555_5555_5555, 1'b0);
      push_cmd(OP_INSERT, 6'd1,  32'sd0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
      push_cmd(OP_SEARCH, 6'd0,  32'sh7fff_ffff, '0, 1'b0);
      push_cmd(OP_SEARCH, 6'd63, 32'sd12345, '0, 1'b0);
      push_cmd(OP_READ,   6'd3,  32'sd0, '0, 1'b0);
      push_cmd(OP_READ,   6'd4,  32'sd0, '0, 1'b0);
      push_cmd(OP_DELETE, 6'd4,  32'sd0, '0, 1'b0);
      push_cmd(OP_INSERT, 6'd63, 32'sd9, 64'h1234_5678_9abc_def0, 1'b0);
      // duplicate key: search must give the lowest position
      push_cmd(OP_INSERT, 6'd1,  -32'sd1, 64'h0123_4567_89ab_cdef, 1'b0);
      push_cmd(OP_SEARCH, 6'd17, -32'sd1, '0, 1'b0);
      push_cmd(OP_DELETE, 6'd0,  32'sd0, '0, 1'b0);
      push_cmd(OP_DELETE, 6'd3,  32'sd0, '0, 1'b0);
      push_cmd(OP_READ,   6'd0,  32'sd0, '0, 1'b0);
      push_cmd(OP_READ,   6'd2,  32'sd0, '0, 1'b0);

      // random part swings between filling up and draining down
      growing = 1'b1;
      for (int n = 0; n < 1800; n++) begin
         if (gen_cnt == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
         else if (gen_cnt == 0 && $urandom_range(3) == 0) growing = 1'b1;
         else if ($urandom_range(99) < 2) growing = !growing;
         r = $urandom_range(99);
         if (r < (growing ? 50 : 15)) op = OP_INSERT;
         else if (r < 65) op = OP_DELETE;
         else if (r < 85) op = OP_SEARCH;
         else op = OP_READ;

         if (op == OP_SEARCH || $urandom_range(99) < 15) begin
            idx = IDX_W'($urandom_range(63));
         end else if (op == OP_INSERT) begin
            idx = IDX_W'($urandom_range((gen_cnt < DEPTH) ? gen_cnt : DEPTH - 1));
         end else begin
            idx = IDX_W'((gen_cnt > 0) ? $urandom_range(gen_cnt - 1) : $urandom_range(63));
         end

         if (op == OP_SEARCH && recent_keys.size() > 0 && $urandom_range(1) == 1)
            key = recent_keys[$urandom_range(recent_keys.size() - 1)];
         else
            key = pick_key();

         if ($urandom_range(9) == 0) pay = $urandom_range(1) ? '1 : '0;
         else pay = {$urandom, $urandom};

         push_cmd(op, idx, key, pay, (n % 450) == 225);
      end
   endtask

   task automatic flag_error(input string msg);
      err_cnt++;
      if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // items change at the falling edge; the head item stays up until taken
   always @(negedge clock) begin : feed_proc
      list_cmd_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accept_seen) begin
         if (start) issued = issued + 1;
         if (cmd_backlog.size() > 0
             && !(cmd_backlog[0].hold_until_idle && rsp_due.size() > 0)
             && ((issued >= 700 && issued < 1000) || $urandom_range(99) >= 37)) begin
            nxt = cmd_backlog.pop_front();
            start       <= 1'b1;
            req_opcode  <= nxt.op;
            req_index   <= nxt.idx;
            req_key     <= nxt.key;
            req_payload <= nxt.pay;
         end else begin
            start       <= 1'b0;
            req_opcode  <= 2'($urandom_range(3));
            req_index   <= IDX_W'($urandom_range(63));
            req_key     <= $urandom;
            req_payload <= {$urandom, $urandom};
         end
      end
   end

   always @(posedge clock) begin : watch_proc
      list_rsp_type want;
      accept_seen <= !reset && start && !busy;
      if (!reset) begin
         // results before the new item, so a same-edge result pops the older one
         if (rsp_strobe) begin
            if (rsp_due.size() == 0) begin
               flag_error($sformatf("unexpected result status=%0d idx=%0d key=%0d pay=%h cnt=%0d",
                  rsp_status, rsp_found_index, rsp_entry_key, rsp_entry_payload, rsp_count));
            end else begin
               want = rsp_due.pop_front();
               if (rsp_status !== want.status || rsp_found_index !== want.pos
                   || rsp_entry_key !== want.key || rsp_entry_payload !== want.pay
                   || rsp_count !== want.count)
                  flag_error($sformatf({"mismatch exp status=%0d idx=%0d key=%0d pay=%h cnt=%0d",
                     " got status=%0d idx=%0d key=%0d pay=%h cnt=%0d"},
                     want.status, want.pos, want.key, want.pay, want.count,
                     rsp_status, rsp_found_index, rsp_entry_key, rsp_entry_payload,
                     rsp_count));
            end
         end
         if (start && !busy)
            rsp_due.push_back(apply_list_op(req_opcode, req_index, req_key, req_payload));
      end
   end

   initial begin
      build_traffic();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (cmd_backlog.size() != 0 || start || rsp_due.size() != 0) @(posedge clock);
      // a stray late result would show within one lookup sweep
      repeat (DEPTH + 8) @(posedge clock);
      if (err_cnt == 0) begin
         $display("positional_list_table_core_tb OK");
      end else begin
         $display("positional_list_table_core_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("positional_list_table_core_tb NOT OK");
      $finish;
   end

endmodule
